FILE: design/mtt_pkg.sv
package mtt_pkg;

  localparam int unsigned MSG_W        = 64;
  localparam int unsigned SES_W        = 32;
  localparam int unsigned AGE_W        = 16;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT + 1);

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PURGE  = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [SES_W-1:0] ses;
    logic [MSG_W-1:0] msg;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // capture request, rewind walk
    logic eval;    // act on the current entry
    logic finish;  // emit the closing result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stall;   // current entry waits for the output register
    logic done;    // current entry ends the walk
    logic push_ok; // output register can take a result
  } sts_t;

endpackage

FILE: design/mtt_ctrl.sv
module mtt_ctrl
  import mtt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.stall && sts_i.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.push_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // closing result is never dropped while the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !sts_i.push_ok) |=> (state_q == ST_FINISH))
    else $error("finish left while output blocked");

endmodule

FILE: design/mtt_datapath.sv
module mtt_datapath
  import mtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [KIND_W-1:0]     in_kind_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_we_i,
  input  logic [AGE_W-1:0]      cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [AGE_W-1:0]         timeout_q;
  kind_e                    kind_q;
  logic [MSG_W-1:0]         msg_q;
  logic [SES_W-1:0]         ses_q;
  logic [IDX_W-1:0]         idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rd_q;
  logic                     found_q;
  logic                     pend_valid_q;
  logic [MSG_W-1:0]         pend_msg_q;
  logic [SES_W-1:0]         pend_ses_q;
  logic [CNT_W-1:0]         cnt_q;

  logic                     out_valid_q;
  logic                     out_found_q, out_full_q, out_exp_q, out_last_q;
  logic [MSG_W-1:0]         out_msg_q;
  logic [SES_W-1:0]         out_ses_q;

  logic             entry_v, out_free, hit, expire, stall, done, advance, step;
  logic             wr_en, push_pend, push_final;
  logic [AGE_W-1:0] age_inc;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;

  assign entry_v  = valid_q[idx_q];
  assign out_free = !out_valid_q || out_ready_i;
  assign age_inc  = (rd_q.age == '1) ? rd_q.age : rd_q.age + 1'b1;

  always_comb begin
    hit     = 1'b0;
    expire  = 1'b0;
    wr_en   = 1'b0;
    wr_data = rd_q;
    case (kind_q)
      KIND_ADD: begin
        hit         = !entry_v;
        wr_en       = !entry_v;
        wr_data.age = '0;
        wr_data.ses = ses_q;
        wr_data.msg = msg_q;
      end
      KIND_REMOVE: begin
        hit = entry_v && (rd_q.msg == msg_q);
      end
      KIND_PURGE: begin
        hit = entry_v && (rd_q.ses == ses_q);
      end
      KIND_TICK: begin
        if (entry_v) begin
          expire      = (age_inc >= timeout_q) && (cnt_q < CNT_W'(RESULT_LIMIT));
          wr_en       = !expire;
          wr_data.age = age_inc;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // an expiry must move the held one out first
  assign stall = cmd_i.eval && expire && pend_valid_q && !out_free;
  assign done  = (idx_q == LAST_IDX) ||
                 (hit && (kind_q == KIND_ADD || kind_q == KIND_REMOVE));
  assign step       = cmd_i.eval && !stall;
  assign advance    = step && !done;
  assign push_pend  = step && expire && pend_valid_q;
  assign push_final = cmd_i.finish && out_free;

  // read address leads the walk by one so data lines up with idx_q
  always_comb begin
    if (cmd_i.start) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = IDX_W'(idx_q + 1'b1);
    end else begin
      rd_addr = idx_q;
    end
  end

  assign sts_o.stall   = stall;
  assign sts_o.done    = done;
  assign sts_o.push_ok = out_free;

  always_ff @(posedge clk_i) begin
    if (step && wr_en) begin
      mem[idx_q] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= KIND_ADD;
      idx_q        <= '0;
      valid_q      <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else if (cmd_i.start) begin
      kind_q       <= kind_e'(in_kind_i);
      idx_q        <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (advance) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
      end
      if (step && hit) begin
        found_q <= 1'b1;
      end
      if (step && kind_q == KIND_ADD && hit) begin
        valid_q[idx_q] <= 1'b1;
      end else if (step && (expire || (hit && kind_q != KIND_ADD))) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (step && expire) begin
        pend_valid_q <= 1'b1;
        cnt_q        <= CNT_W'(cnt_q + 1'b1);
      end
    end
  end

  // request fields and held expiry; ids read as zero when nothing expired
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      msg_q      <= in_data_i[MSG_W-1:0];
      ses_q      <= in_data_i[MSG_W +: SES_W];
      pend_msg_q <= '0;
      pend_ses_q <= '0;
    end else if (step && expire) begin
      pend_msg_q <= rd_q.msg;
      pend_ses_q <= rd_q.ses;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_pend || push_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_pend) begin
      out_found_q <= 1'b0;
      out_full_q  <= 1'b0;
      out_exp_q   <= 1'b1;
      out_msg_q   <= pend_msg_q;
      out_ses_q   <= pend_ses_q;
      out_last_q  <= 1'b0;
    end else if (push_final) begin
      out_last_q <= 1'b1;
      if (kind_q == KIND_TICK) begin
        out_found_q <= 1'b0;
        out_full_q  <= 1'b0;
        out_exp_q   <= pend_valid_q;
        out_msg_q   <= pend_msg_q;
        out_ses_q   <= pend_ses_q;
      end else begin
        out_found_q <= found_q;
        out_full_q  <= (kind_q == KIND_ADD) && !found_q;
        out_exp_q   <= 1'b0;
        out_msg_q   <= '0;
        out_ses_q   <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {5'd0, out_ses_q, out_msg_q, out_exp_q, out_full_q, out_found_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RESULT_LIMIT))
    else $error("expiry count past limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (kind_q == KIND_TICK && pend_valid_q))
    else $error("stall outside a tick with a held expiry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(idx_q))
    else $error("walk moved during stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_final |=> (out_valid_q && out_last_q))
    else $error("closing result not marked last");

endmodule

FILE: design/message_timeout_table.sv
// Pending message timeout table.
// Slave stream carries one request per transfer: tuser is the kind (add,
// remove by id, purge a session, tick), tdata the message and session ids.
// Master stream returns the results; tlast marks the final result of a
// request. Add, remove and purge give one result; a tick gives one result per
// expired entry (at most 16) in slot order, or a single empty result.
// Timing: barring a tick stall, the table is walked one slot per cycle from
// slot 0. Add stops at the first free slot, remove at the first match;
// purge and tick visit every slot. A request is accepted in the idle state,
// walks the table and then enters the finish state; the closing result is on
// the master stream the cycle after the finish cycle.
// The walk rate is set by the single read port of the entry memory.
// A finished result sits in an output register, so the next request is taken
// while it still waits. When the receiver stalls, a tick holds one expiry and
// pauses its walk at the next expired slot, and every request waits in its
// finish cycle, until the output register drains.
// Reset empties the table (valid bits cleared) and sets the timeout to 10
// ticks; cfg_we_i writes the timeout and must only be used while idle.
module message_timeout_table
  import mtt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // message_id[63:0], session_id[95:64]
  input  logic [KIND_W-1:0]     s_axis_tuser,  // kind[1:0]
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found[0], table_full[1],
                                               // expired_valid[2],
                                               // expired_message_id[66:3],
                                               // expired_session_id[98:67], zero pad
  output logic                  m_axis_tlast,  // last
  // timeout register
  input  logic                  cfg_we_i,
  input  logic [AGE_W-1:0]      cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  mtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mtt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: tb/testbench.sv
// Testbench for the pending message timeout table.
// One initial block runs the named tests in turn. They share issue_request,
// which offers one request on the slave stream and, on acceptance, runs the
// table predictor. result_check compares every accepted result against the
// oldest expected one. result_sink drives m_axis_tready on a pattern of its
// own and can hold the result stream off for a long stretch.
module testbench;
  import mtt_pkg::*;

  localparam int unsigned TABLE_ENTRIES   = 16;
  localparam int unsigned CLK_HALF        = 6;
  localparam int unsigned SETTLE_CYCLES   = TABLE_ENTRIES + 4;
  localparam int unsigned HOLDOFF_CYCLES  = 300;
  localparam int unsigned WATCHDOG_CYCLES = 400000;
  localparam int unsigned REPORT_CAP      = 60;

  // one expected result, in the order of the result stream fields
  typedef struct packed {
    logic             found;
    logic             full;
    logic             expired;
    logic [MSG_W-1:0] msg;
    logic [SES_W-1:0] ses;
    logic             last;
  } outcome_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // message_id[63:0], session_id[95:64]
  logic [KIND_W-1:0]     s_axis_tuser  = '0;  // kind[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // found[0], table_full[1],
                                              // expired_valid[2],
                                              // expired_message_id[66:3],
                                              // expired_session_id[98:67], zero pad
  logic                  m_axis_tlast;        // last
  logic                  cfg_we_i      = 1'b0;
  logic [AGE_W-1:0]      cfg_wdata_i   = '0;

  message_timeout_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // predictor state: our own copy of the table and the timeout register
  logic             slot_used [TABLE_ENTRIES];
  logic [MSG_W-1:0] slot_msg  [TABLE_ENTRIES];
  logic [SES_W-1:0] slot_ses  [TABLE_ENTRIES];
  logic [AGE_W-1:0] slot_age  [TABLE_ENTRIES];
  logic [AGE_W-1:0] timeout_ref;

  outcome_t         expected_results[$];
  int unsigned      mismatch_count;

  // sender burst control
  bit               gaps_on;
  int               burst_left;
  // bumped by a test to ask result_sink for one long hold-off
  int               holdoff_gen;
  // a few sessions shared by many adds, so purges hit several entries
  logic [SES_W-1:0] session_pool[4];

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // append one result at the tail of the expected queue
  task automatic queue_expected(outcome_t res);
    expected_results.insert(expected_results.size(), res);
  endtask

  // Walk the predicted table the way the block does and queue the results
  // that one accepted request causes.
  task automatic predict_request(kind_e kind, logic [MSG_W-1:0] msg, logic [SES_W-1:0] ses);
    outcome_t res;
    int       hit;
    int       n;
    int       gone[TABLE_ENTRIES];
    res = '0;
    res.last = 1'b1;
    hit = -1;
    n = 0;
    case (kind)
      KIND_ADD: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (hit < 0 && !slot_used[i]) hit = i;
        if (hit >= 0) begin
          slot_used[hit] = 1'b1;
          slot_msg[hit]  = msg;
          slot_ses[hit]  = ses;
          slot_age[hit]  = '0;
          res.found = 1'b1;
        end else begin
          res.full = 1'b1;
        end
        queue_expected(res);
      end
      KIND_REMOVE: begin
        // only the lowest matching slot goes
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (hit < 0 && slot_used[i] && slot_msg[i] == msg) hit = i;
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          res.found = 1'b1;
        end
        queue_expected(res);
      end
      KIND_PURGE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i] && slot_ses[i] == ses) begin
            slot_used[i] = 1'b0;
            res.found = 1'b1;
          end
        queue_expected(res);
      end
      default: begin
        // tick: age every live entry (saturating), drop the ones at timeout
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i]) begin
            if (slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
            if (slot_age[i] >= timeout_ref && n < RESULT_LIMIT) begin
              slot_used[i] = 1'b0;
              gone[n] = i;
              n++;
            end
          end
        if (n == 0) begin
          queue_expected(res);
        end else begin
          for (int j = 0; j < n; j++) begin
            res = '0;
            res.expired = 1'b1;
            res.msg = slot_msg[gone[j]];
            res.ses = slot_ses[gone[j]];
            res.last = (j == n - 1);
            queue_expected(res);
          end
        end
      end
    endcase
  endtask

  // Offer one request; returns at the edge where it is accepted, with
  // tvalid still high so a following request goes out back to back.
  task automatic send_request(kind_e kind, logic [MSG_W-1:0] msg, logic [SES_W-1:0] ses);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ses, msg};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(kind, msg, ses);
  endtask

  // Bursts of random length with random gaps in between, when gaps are on.
  task automatic issue_request(kind_e kind, logic [MSG_W-1:0] msg, logic [SES_W-1:0] ses);
    if (gaps_on && burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    send_request(kind, msg, ses);
    burst_left--;
  endtask

  // Stop offering and wait for every expected result, then let the block
  // settle a full walk so that it is surely idle.
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [AGE_W-1:0] value);
    wait_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_ref = value;
  endtask

  // random live slot, or -1 when the table is empty
  function automatic int pick_live_slot();
    int live;
    int nth;
    live = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i]) live++;
    if (live == 0) return -1;
    nth = $urandom_range(0, live - 1);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i]) begin
        if (nth == 0) return i;
        nth--;
      end
    return -1;
  endfunction

  // Mostly meaningful requests: removes and purges aim at live entries,
  // adds reuse a few sessions and now and then a live id. The rest is noise.
  task automatic send_random_request();
    int               pick;
    int               slot;
    kind_e            kind;
    logic [MSG_W-1:0] msg;
    logic [SES_W-1:0] ses;
    pick = $urandom_range(0, 99);
    msg  = {$urandom, $urandom};
    ses  = $urandom;
    slot = pick_live_slot();
    if (pick < 40) begin
      kind = KIND_ADD;
      if ($urandom_range(0, 9) < 7) ses = session_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) == 0 && slot >= 0) msg = slot_msg[slot];
    end else if (pick < 60) begin
      kind = KIND_REMOVE;
      if (slot >= 0 && $urandom_range(0, 3) != 0) msg = slot_msg[slot];
    end else if (pick < 70) begin
      kind = KIND_PURGE;
      if (slot >= 0 && $urandom_range(0, 3) != 0) ses = slot_ses[slot];
    end else begin
      kind = KIND_TICK;
    end
    issue_request(kind, msg, ses);
  endtask

  // Empty-table cases, duplicate ids, remove of the lowest match, purge.
  task automatic test_basic_ops();
    gaps_on = 1'b1;
    issue_request(KIND_TICK, '1, '1);
    issue_request(KIND_REMOVE, '0, '0);
    issue_request(KIND_PURGE, '0, '0);
    issue_request(KIND_ADD, '0, '0);
    issue_request(KIND_ADD, '1, '1);
    issue_request(KIND_ADD, '1, 32'h0000_0005);
    issue_request(KIND_ADD, 64'h1, '0);
    issue_request(KIND_REMOVE, '1, '0);
    issue_request(KIND_REMOVE, '1, '0);
    issue_request(KIND_PURGE, '1, '0);
    issue_request(KIND_PURGE, '0, '1);
  endtask

  // Fill the table, get one add refused, then expire all sixteen at once
  // with a timeout of 1.
  task automatic test_full_table();
    int live;
    write_timeout(16'd1);
    live = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i]) live++;
    for (int i = live; i < TABLE_ENTRIES; i++)
      issue_request(KIND_ADD, (i % 2) ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555,
                    (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
    issue_request(KIND_ADD, {$urandom, $urandom}, $urandom);
    issue_request(KIND_TICK, '0, '0);
  endtask

  task automatic test_random_phase(logic [AGE_W-1:0] timeout, int count, bit gaps);
    write_timeout(timeout);
    gaps_on = gaps;
    repeat (count) send_random_request();
  endtask

  // Hold the result stream off while requests keep coming back to back, so
  // the block fills and stalls its request side.
  task automatic test_backpressure();
    write_timeout(16'd3);
    gaps_on = 1'b0;
    holdoff_gen++;
    repeat (20) begin
      if ($urandom_range(0, 2) == 0) issue_request(KIND_TICK, '0, '0);
      else issue_request(KIND_ADD, {$urandom, $urandom}, session_pool[$urandom_range(0, 3)]);
    end
  endtask

  // result_sink: ready on a randomly chosen pattern, redrawn after a span of random
  // length, plus one long hold-off whenever holdoff_gen moves.
  initial begin : result_sink
    int mode;
    int span;
    int seen;
    int hold;
    mode = 0;
    span = 0;
    seen = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_gen != seen) begin
        seen = holdoff_gen;
        hold = HOLDOFF_CYCLES;
      end
      if (span <= 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 80);
      end
      span--;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (span % 3 == 0);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[0] !== want.found)
          report_mismatch($sformatf("found %b, want %b", m_axis_tdata[0], want.found));
        if (m_axis_tdata[1] !== want.full)
          report_mismatch($sformatf("table_full %b, want %b", m_axis_tdata[1], want.full));
        if (m_axis_tdata[2] !== want.expired)
          report_mismatch($sformatf("expired_valid %b, want %b", m_axis_tdata[2],
                                    want.expired));
        if (m_axis_tdata[66:3] !== want.msg)
          report_mismatch($sformatf("expired_message_id %h, want %h", m_axis_tdata[66:3],
                                    want.msg));
        if (m_axis_tdata[98:67] !== want.ses)
          report_mismatch($sformatf("expired_session_id %h, want %h", m_axis_tdata[98:67],
                                    want.ses));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  initial begin : watchdog
    #(2 * CLK_HALF * WATCHDOG_CYCLES);
    $display("message_timeout_table verification failed");
    $finish;
  end

  initial begin : sequencer
    mismatch_count = 0;
    holdoff_gen    = 0;
    burst_left     = 0;
    gaps_on        = 1'b0;
    timeout_ref    = TIMEOUT_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_msg[i]  = '0;
      slot_ses[i]  = '0;
      slot_age[i]  = '0;
    end
    session_pool[0] = '1;
    for (int i = 1; i < 4; i++) session_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_full_table();
    test_random_phase(16'hFFFF, 15, 1'b1);
    test_random_phase(16'd2, 15, 1'b0);
    test_random_phase(16'($urandom_range(3, 12)), 15, 1'b1);
    test_backpressure();
    test_random_phase(16'd1, 8, 1'b1);
    test_random_phase(16'($urandom_range(1, 65535)), 6, 1'b0);
    test_random_phase(16'($urandom_range(4, 9)), 8, 1'b1);
    wait_until_idle();

    if (mismatch_count == 0) begin
      $display("message_timeout_table verification clean");
    end else begin
      $display("message_timeout_table verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mtt_pkg.sv
design/mtt_ctrl.sv
design/mtt_datapath.sv
design/message_timeout_table.sv
tb/testbench.sv
